@@ src/mwa_pkg.sv @@
// Shared constants and types of the moving-window average filter.
`default_nettype none

package mwa_pkg;

	localparam int CHANNELS      = 4;
	localparam int SAMPLE_BITS   = 32;
	localparam int AVG_BITS      = 32;
	localparam int COUNT_BITS    = 11;
	localparam int TICK_BITS     = 16;
	localparam int DEPTH_DEFAULT = 1024;

	localparam logic [TICK_BITS-1:0] TICKS_RESET = 16'd1000;

	typedef enum logic [1:0] {
		PH_WAIT,
		PH_GROW,
		PH_FROZEN
	} phase_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_WRITE,
		ST_ADD,
		ST_SEL,
		ST_DIV,
		ST_SIGN,
		ST_DONE
	} state_t;

endpackage

`default_nettype wire

@@ src/mwa_if.sv @@
// Handshake interfaces of the filter: sample words in, average words out, configuration.
`default_nettype none

interface mwa_in_if;
	logic                                   valid;
	logic                                   ready;
	logic                                   command;
	logic signed [mwa_pkg::SAMPLE_BITS-1:0] sample_ch0;
	logic signed [mwa_pkg::SAMPLE_BITS-1:0] sample_ch1;
	logic signed [mwa_pkg::SAMPLE_BITS-1:0] sample_ch2;
	logic signed [mwa_pkg::SAMPLE_BITS-1:0] sample_ch3;

	modport source (output valid, command, sample_ch0, sample_ch1, sample_ch2, sample_ch3,
		input ready);
	modport sink (input valid, command, sample_ch0, sample_ch1, sample_ch2, sample_ch3,
		output ready);
endinterface

interface mwa_out_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [mwa_pkg::AVG_BITS-1:0]   average_ch0;
	logic signed [mwa_pkg::AVG_BITS-1:0]   average_ch1;
	logic signed [mwa_pkg::AVG_BITS-1:0]   average_ch2;
	logic signed [mwa_pkg::AVG_BITS-1:0]   average_ch3;
	logic        [mwa_pkg::COUNT_BITS-1:0] window_count;
	logic                                  window_frozen;

	modport source (output valid, average_ch0, average_ch1, average_ch2, average_ch3,
		window_count, window_frozen, input ready);
	modport sink (input valid, average_ch0, average_ch1, average_ch2, average_ch3,
		window_count, window_frozen, output ready);
endinterface

interface mwa_cfg_if;
	logic                                valid;
	logic                                ready;
	logic [mwa_pkg::TICK_BITS-1:0]       integration_ticks;

	modport source (output valid, integration_ticks, input ready);
	modport sink (input valid, integration_ticks, output ready);
endinterface

`default_nettype wire

@@ src/moving_window_average_filter.sv @@
// Four-channel moving-window average with bit-serial sum update and division.
//
//   channel   | modport | word
//   ----------+---------+---------------------------------------------------
//   samples   | sink    | command, sample_ch0..3 (tick or sample vector)
//   averages  | source  | average_ch0..3, window_count, window_frozen
//   cfg       | sink    | integration_ticks (ready while idle, restarts filter)
//
// A tick is taken in the idle state. A sample vector passes accept, read, write,
// SUM_W-bit serial add, select, SUM_W-bit serial divide, AVG_BITS-bit serial sign fix
// and hand-over in that order, the serial steps set by the one-bit-per-cycle adders
// and restoring dividers of each channel.
// Reset leaves the window store uncleared; no clearing pass, words flow at once.
// A configuration word is taken only between vectors and holds the sample input off.
// A finished average waits in the output register while the next word is taken;
// a second result stalls in the hand-over state until the first is taken.
`default_nettype none

module moving_window_average_filter #(
	parameter int DEPTH = mwa_pkg::DEPTH_DEFAULT
) (
	input  logic      clk,
	input  logic      arst_n,
	mwa_in_if.sink    samples,
	mwa_out_if.source averages,
	mwa_cfg_if.sink   cfg
);

	localparam int CH     = mwa_pkg::CHANNELS;
	localparam int SB     = mwa_pkg::SAMPLE_BITS;
	localparam int AB     = mwa_pkg::AVG_BITS;
	localparam int CW     = mwa_pkg::COUNT_BITS;
	localparam int TW     = mwa_pkg::TICK_BITS;
	localparam int PTR_W  = $clog2(DEPTH);
	localparam int FILL_W = $clog2(DEPTH + 1);
	localparam int SUM_W  = SB + $clog2(DEPTH);
	localparam int CNT_W  = $clog2(SUM_W);
	localparam int ROW_W  = CH * SB;

	mwa_pkg::state_t state_q, state_d;
	mwa_pkg::phase_t phase_q;

	logic [TW-1:0]     ticks_q;
	logic [TW-1:0]     elapsed_q;
	logic [TW-1:0]     elapsed_inc;
	logic [FILL_W-1:0] fill_q;
	logic [PTR_W-1:0]  oldest_q;
	logic [PTR_W-1:0]  newest_q;
	logic              evict_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              out_valid_q;

	logic              in_ready;
	logic              accept_sample;
	logic              accept_tick;
	logic              cfg_write;
	logic              load_out;
	logic              cnt_zero;

	logic [ROW_W-1:0]  window_mem_q [DEPTH];
	logic [ROW_W-1:0]  new_row;

	logic [SB-1:0]     in_smp    [CH];
	logic [SB-1:0]     new_q     [CH];
	logic [SB-1:0]     old_q     [CH];
	logic [SUM_W-1:0]  sum_q     [CH];
	logic [SUM_W-1:0]  neg_q     [CH];
	logic [SUM_W-1:0]  dvd_q     [CH];
	logic [FILL_W-1:0] rem_q     [CH];
	logic [FILL_W-1:0] rem_d     [CH];
	logic [FILL_W:0]   trial     [CH];
	logic [FILL_W:0]   diff      [CH];
	logic [AB-1:0]     avg_q     [CH];
	logic [AB-1:0]     out_avg_q [CH];
	logic [CW-1:0]     out_count_q;
	logic              out_frozen_q;

	logic [CH-1:0]     c1_q, c2_q, c3_q;
	logic [CH-1:0]     c1_d, c2_d, c3_d;
	logic [CH-1:0]     old_n, add_d, add_s, add_n;
	logic [CH-1:0]     ge;
	logic [CH-1:0]     sign_q, seen_q;
	logic [CH-1:0]     sgn_bit;

	assign in_smp[0] = samples.sample_ch0;
	assign in_smp[1] = samples.sample_ch1;
	assign in_smp[2] = samples.sample_ch2;
	assign in_smp[3] = samples.sample_ch3;

	assign elapsed_inc = elapsed_q + 1'b1;
	assign cnt_zero    = (cnt_q == '0);

	// handshake and hand-over control
	always_comb begin
		in_ready      = (state_q == mwa_pkg::ST_IDLE) && !cfg.valid;
		accept_sample = samples.valid && in_ready && !samples.command;
		accept_tick   = samples.valid && in_ready && samples.command;
		cfg_write     = cfg.valid && (state_q == mwa_pkg::ST_IDLE);
		load_out      = (state_q == mwa_pkg::ST_DONE) && (!out_valid_q || averages.ready);
	end

	assign samples.ready = in_ready;
	assign cfg.ready     = (state_q == mwa_pkg::ST_IDLE);

	assign averages.valid         = out_valid_q;
	assign averages.average_ch0   = out_avg_q[0];
	assign averages.average_ch1   = out_avg_q[1];
	assign averages.average_ch2   = out_avg_q[2];
	assign averages.average_ch3   = out_avg_q[3];
	assign averages.window_count  = out_count_q;
	assign averages.window_frozen = out_frozen_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mwa_pkg::ST_IDLE:  if (accept_sample) state_d = mwa_pkg::ST_READ;
			mwa_pkg::ST_READ:  state_d = mwa_pkg::ST_WRITE;
			mwa_pkg::ST_WRITE: state_d = mwa_pkg::ST_ADD;
			mwa_pkg::ST_ADD:   if (cnt_zero) state_d = mwa_pkg::ST_SEL;
			mwa_pkg::ST_SEL:   state_d = mwa_pkg::ST_DIV;
			mwa_pkg::ST_DIV:   if (cnt_zero) state_d = mwa_pkg::ST_SIGN;
			mwa_pkg::ST_SIGN:  if (cnt_zero) state_d = mwa_pkg::ST_DONE;
			mwa_pkg::ST_DONE:  if (load_out) state_d = mwa_pkg::ST_IDLE;
			default:           state_d = mwa_pkg::ST_IDLE;
		endcase
	end

	// one bit per channel per cycle: adders, negator, divider step, sign fix
	always_comb begin
		for (int c = 0; c < CH; c++) begin
			new_row[c*SB +: SB] = new_q[c];
			old_n[c] = ~(evict_q & old_q[c][0]);
			add_d[c] = new_q[c][0] ^ old_n[c] ^ c1_q[c];
			c1_d[c]  = (new_q[c][0] & old_n[c]) | (c1_q[c] & (new_q[c][0] ^ old_n[c]));
			add_s[c] = sum_q[c][0] ^ add_d[c] ^ c2_q[c];
			c2_d[c]  = (sum_q[c][0] & add_d[c]) | (c2_q[c] & (sum_q[c][0] ^ add_d[c]));
			add_n[c] = ~add_s[c] ^ c3_q[c];
			c3_d[c]  = ~add_s[c] & c3_q[c];
			trial[c] = {rem_q[c], dvd_q[c][SUM_W-1]};
			diff[c]  = trial[c] - {1'b0, fill_q};
			ge[c]    = (trial[c] >= {1'b0, fill_q});
			rem_d[c] = ge[c] ? diff[c][FILL_W-1:0] : trial[c][FILL_W-1:0];
			sgn_bit[c] = dvd_q[c][0] ^ (sign_q[c] & seen_q[c]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mwa_pkg::ST_IDLE;
			phase_q     <= mwa_pkg::PH_WAIT;
			ticks_q     <= mwa_pkg::TICKS_RESET;
			elapsed_q   <= '0;
			fill_q      <= '0;
			oldest_q    <= '0;
			newest_q    <= '0;
			evict_q     <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;

			priority if (cfg_write) begin
				ticks_q   <= cfg.integration_ticks;
				phase_q   <= mwa_pkg::PH_WAIT;
				elapsed_q <= '0;
			end else if (accept_tick) begin
				// timer runs only while the window grows
				if (phase_q == mwa_pkg::PH_GROW) begin
					elapsed_q <= elapsed_inc;
					if (elapsed_inc >= ticks_q) phase_q <= mwa_pkg::PH_FROZEN;
				end
			end else if (accept_sample) begin
				if (phase_q == mwa_pkg::PH_WAIT) begin
					phase_q   <= mwa_pkg::PH_GROW;
					elapsed_q <= '0;
					fill_q    <= '0;
					oldest_q  <= '0;
					newest_q  <= '0;
					evict_q   <= 1'b0;
				end else begin
					evict_q <= ((phase_q == mwa_pkg::PH_FROZEN) ||
						(fill_q >= FILL_W'(DEPTH))) && (fill_q != '0);
				end
			end else if (state_q == mwa_pkg::ST_WRITE) begin
				newest_q <= (newest_q == PTR_W'(DEPTH - 1)) ? '0 : newest_q + 1'b1;
				if (evict_q) begin
					oldest_q <= (oldest_q == PTR_W'(DEPTH - 1)) ? '0 : oldest_q + 1'b1;
				end else begin
					fill_q <= fill_q + 1'b1;
				end
			end else begin
				phase_q <= phase_q;
			end

			unique case (state_q)
				mwa_pkg::ST_WRITE, mwa_pkg::ST_SEL: cnt_q <= CNT_W'(SUM_W - 1);
				mwa_pkg::ST_ADD, mwa_pkg::ST_SIGN:  cnt_q <= cnt_q - 1'b1;
				mwa_pkg::ST_DIV: cnt_q <= cnt_zero ? CNT_W'(AB - 1) : cnt_q - 1'b1;
				default:                            cnt_q <= cnt_q;
			endcase

			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (averages.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			mwa_pkg::ST_IDLE: begin
				if (accept_sample) begin
					for (int c = 0; c < CH; c++) begin
						new_q[c] <= in_smp[c];
						// first sample after a restart empties the sums
						if (phase_q == mwa_pkg::PH_WAIT) sum_q[c] <= '0;
					end
				end
			end
			mwa_pkg::ST_READ: begin
				for (int c = 0; c < CH; c++) begin
					old_q[c] <= window_mem_q[oldest_q][c*SB +: SB];
				end
			end
			mwa_pkg::ST_WRITE: begin
				window_mem_q[newest_q] <= new_row;
				c1_q <= '1;
				c2_q <= '0;
				c3_q <= '1;
			end
			mwa_pkg::ST_ADD: begin
				// advance LSB first; arithmetic shift sign-extends the operands
				for (int c = 0; c < CH; c++) begin
					new_q[c] <= {new_q[c][SB-1], new_q[c][SB-1:1]};
					old_q[c] <= {old_q[c][SB-1], old_q[c][SB-1:1]};
					sum_q[c] <= {add_s[c], sum_q[c][SUM_W-1:1]};
					neg_q[c] <= {add_n[c], neg_q[c][SUM_W-1:1]};
				end
				c1_q <= c1_d;
				c2_q <= c2_d;
				c3_q <= c3_d;
			end
			mwa_pkg::ST_SEL: begin
				for (int c = 0; c < CH; c++) begin
					sign_q[c] <= sum_q[c][SUM_W-1];
					dvd_q[c]  <= sum_q[c][SUM_W-1] ? neg_q[c] : sum_q[c];
					rem_q[c]  <= '0;
				end
				seen_q <= '0;
			end
			mwa_pkg::ST_DIV: begin
				for (int c = 0; c < CH; c++) begin
					rem_q[c] <= rem_d[c];
					dvd_q[c] <= {dvd_q[c][SUM_W-2:0], ge[c]};
				end
			end
			mwa_pkg::ST_SIGN: begin
				// for a negative sum, negate the quotient serially: invert every bit above the first one
				for (int c = 0; c < CH; c++) begin
					dvd_q[c] <= {1'b0, dvd_q[c][SUM_W-1:1]};
					avg_q[c] <= {sgn_bit[c], avg_q[c][AB-1:1]};
				end
				seen_q <= seen_q | {dvd_q[3][0], dvd_q[2][0], dvd_q[1][0], dvd_q[0][0]};
			end
			mwa_pkg::ST_DONE: begin
				if (load_out) begin
					for (int c = 0; c < CH; c++) begin
						out_avg_q[c] <= avg_q[c];
					end
					out_count_q  <= CW'(fill_q);
					out_frozen_q <= (phase_q == mwa_pkg::PH_FROZEN);
				end
			end
			default: begin
				seen_q <= seen_q;
			end
		endcase
	end

endmodule

`default_nettype wire

@@ tb/sv/tb.sv @@
// Testbench of the moving-window average filter: word driver, average monitor and window predictor.

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WINDOW_DEPTH  = mwa_pkg::DEPTH_DEFAULT;
	localparam int SETTLE_CYCLES = 300;
	localparam int LONG_HOLD     = 1500;
	localparam int CYCLE_LIMIT   = 1000000;

	localparam logic CMD_SAMPLE = 1'b0;
	localparam logic CMD_TICK   = 1'b1;

	// preferred value shapes of a random sample vector
	localparam int LEAN_ANY   = 0;
	localparam int LEAN_HIGH  = 1;
	localparam int LEAN_LOW   = 2;
	localparam int LEAN_SMALL = 3;
	localparam int LEAN_EDGE  = 4;

	localparam int S_MAX = 32'h7FFF_FFFF;
	localparam int S_MIN = int'(32'h8000_0000);

	typedef struct packed {
		logic                                                   command;
		logic [mwa_pkg::CHANNELS-1:0][mwa_pkg::SAMPLE_BITS-1:0] value;
	} filter_word_t;

	typedef struct packed {
		logic [mwa_pkg::CHANNELS-1:0][mwa_pkg::AVG_BITS-1:0] average;
		logic [mwa_pkg::COUNT_BITS-1:0]                      count;
		logic                                                frozen;
	} average_word_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	mwa_in_if  samples();
	mwa_out_if averages();
	mwa_cfg_if cfg();

	moving_window_average_filter #(.DEPTH(WINDOW_DEPTH)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.samples(samples),
		.averages(averages),
		.cfg(cfg)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	filter_word_t  pending_words[$];
	average_word_t expected_averages[$];
	filter_word_t  on_offer;
	int            words_queued  = 0;
	int            words_taken   = 0;
	int            samples_taken = 0;
	int            fail_count    = 0;
	int            cycle_count   = 0;
	logic          tail_quiet    = 1'b0;

	// window predictor
	mwa_pkg::phase_t                                        win_phase;
	logic [mwa_pkg::TICK_BITS-1:0]                          ticks_limit;
	int                                                     ticks_seen;
	longint                                                 running_sum [mwa_pkg::CHANNELS];
	logic [mwa_pkg::CHANNELS-1:0][mwa_pkg::SAMPLE_BITS-1:0] window_mem [WINDOW_DEPTH];
	int                                                     fill;
	int                                                     oldest;
	int                                                     newest;

	task automatic restart_window(input logic [mwa_pkg::TICK_BITS-1:0] limit);
		ticks_limit = limit;
		win_phase   = mwa_pkg::PH_WAIT;
		ticks_seen  = 0;
		fill        = 0;
		oldest      = 0;
		newest      = 0;
		for (int c = 0; c < mwa_pkg::CHANNELS; c++)
			running_sum[c] = 0;
	endtask

	task automatic predict_word(input filter_word_t w);
		average_word_t r;
		longint        q;
		if (w.command == CMD_TICK) begin
			if (win_phase == mwa_pkg::PH_GROW) begin
				ticks_seen++;
				if (ticks_seen >= ticks_limit)
					win_phase = mwa_pkg::PH_FROZEN;
			end
		end else begin
			if (win_phase == mwa_pkg::PH_WAIT) begin
				restart_window(ticks_limit);
				win_phase = mwa_pkg::PH_GROW;
			end
			// evict the oldest vector once frozen or full
			if ((win_phase == mwa_pkg::PH_FROZEN || fill >= WINDOW_DEPTH) && fill > 0) begin
				for (int c = 0; c < mwa_pkg::CHANNELS; c++)
					running_sum[c] -= longint'($signed(window_mem[oldest][c]));
				oldest = (oldest + 1) % WINDOW_DEPTH;
				fill--;
			end
			window_mem[newest] = w.value;
			for (int c = 0; c < mwa_pkg::CHANNELS; c++)
				running_sum[c] += longint'($signed(w.value[c]));
			newest = (newest + 1) % WINDOW_DEPTH;
			fill++;
			for (int c = 0; c < mwa_pkg::CHANNELS; c++) begin
				q = running_sum[c] / longint'(fill);
				r.average[c] = q[mwa_pkg::AVG_BITS-1:0];
			end
			r.count  = fill[mwa_pkg::COUNT_BITS-1:0];
			r.frozen = (win_phase == mwa_pkg::PH_FROZEN);
			expected_averages.push_back(r);
		end
	endtask

	function automatic filter_word_t vec(input int a, input int b, input int c, input int d);
		filter_word_t w;
		w.command = CMD_SAMPLE;
		w.value   = {d[31:0], c[31:0], b[31:0], a[31:0]};
		return w;
	endfunction

	function automatic filter_word_t tick();
		filter_word_t w;
		w.command = CMD_TICK;
		// the channel fields are unused on a tick, so fill them with junk
		for (int c = 0; c < mwa_pkg::CHANNELS; c++)
			w.value[c] = $urandom;
		return w;
	endfunction

	function automatic filter_word_t make_sample(input int lean);
		filter_word_t w;
		int           shape;
		w.command = CMD_SAMPLE;
		for (int c = 0; c < mwa_pkg::CHANNELS; c++) begin
			shape = ($urandom_range(0, 1) == 0) ? lean : $urandom_range(LEAN_ANY, LEAN_EDGE);
			case (shape)
			LEAN_HIGH: w.value[c] = 32'h7FFF_FFFF - $urandom_range(0, 65535);
			LEAN_LOW: w.value[c] = 32'h8000_0000 + $urandom_range(0, 65535);
			LEAN_SMALL: w.value[c] = $urandom_range(0, 2000) - 1000;
			LEAN_EDGE: begin
				case ($urandom_range(0, 4))
				0: w.value[c] = 32'h8000_0000;
				1: w.value[c] = 32'h7FFF_FFFF;
				2: w.value[c] = 32'h0000_0000;
				3: w.value[c] = 32'hFFFF_FFFF;
				default: w.value[c] = 32'h0000_0001;
				endcase
			end
			default: w.value[c] = $urandom;
			endcase
		end
		return w;
	endfunction

	task automatic push_word(input filter_word_t w);
		pending_words.push_back(w);
		words_queued++;
	endtask

	// wait until every word is taken, every average is out and the block is quiet
	task automatic settle();
		while (words_taken != words_queued)
			@(posedge clk);
		while (expected_averages.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_ticks(input logic [mwa_pkg::TICK_BITS-1:0] limit);
		@(posedge clk);
		cfg.valid             <= 1'b1;
		cfg.integration_ticks <= limit;
		do
			@(posedge clk);
		while (!cfg.ready);
		cfg.valid <= 1'b0;
		restart_window(limit);
	endtask

	// one setting of the register, then random words; ignored ticks do not count
	task automatic run_phase(input logic [mwa_pkg::TICK_BITS-1:0] limit, input int want,
		input int tick_pct, input int lean);
		int useful;
		int ticks_left;
		bit started;
		useful     = 0;
		ticks_left = limit;
		started    = 1'b0;
		settle();
		write_ticks(limit);
		repeat ($urandom_range(0, 2)) push_word(tick());
		while (useful < want) begin
			if (started && $urandom_range(0, 99) < tick_pct) begin
				push_word(tick());
				if (ticks_left > 0) begin
					ticks_left--;
					useful++;
				end
			end else begin
				push_word(make_sample(lean));
				started = 1'b1;
				useful++;
			end
		end
	endtask

	// word driver
	int send_gap    = 0;
	bit send_lively = 1'b1;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			send_gap    = 0;
			send_lively = 1'b1;
		end else begin
			if (samples.valid && samples.ready) begin
				predict_word(on_offer);
				words_taken <= words_taken + 1;
				if (on_offer.command == CMD_SAMPLE)
					samples_taken <= samples_taken + 1;
			end
			if (!samples.valid || samples.ready) begin
				if ($urandom_range(0, 63) == 0)
					send_lively = !send_lively;
				if (send_gap > 0) begin
					send_gap--;
					samples.valid <= 1'b0;
				end else if (pending_words.size() == 0) begin
					samples.valid <= 1'b0;
				end else if (send_lively && !tail_quiet && $urandom_range(0, 3) == 0) begin
					send_gap = $urandom_range(0, 6);
					samples.valid <= 1'b0;
				end else begin
					on_offer = pending_words.pop_front();
					samples.valid      <= 1'b1;
					samples.command    <= on_offer.command;
					samples.sample_ch0 <= on_offer.value[0];
					samples.sample_ch1 <= on_offer.value[1];
					samples.sample_ch2 <= on_offer.value[2];
					samples.sample_ch3 <= on_offer.value[3];
				end
			end
		end
	end

	// receiver: short random stalls, and two long hold-offs to back the block up
	int recv_gap    = 0;
	int hold_left   = 0;
	int hold_stage  = 0;
	bit recv_lively = 1'b1;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			recv_gap   = 0;
			hold_left  = 0;
			hold_stage = 0;
		end else begin
			if ($urandom_range(0, 63) == 0)
				recv_lively = !recv_lively;
			if (hold_left > 0) begin
				hold_left--;
				averages.ready <= 1'b0;
			end else if (hold_stage < 2 && samples_taken >= (hold_stage == 0 ? 60 : 400)) begin
				hold_left = LONG_HOLD;
				hold_stage++;
				averages.ready <= 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap--;
				averages.ready <= 1'b0;
			end else if (recv_lively && !tail_quiet && $urandom_range(0, 3) == 0) begin
				recv_gap = $urandom_range(0, 6);
				averages.ready <= 1'b0;
			end else begin
				averages.ready <= 1'b1;
			end
		end
	end

	// average monitor
	always @(posedge clk) begin
		average_word_t got;
		average_word_t want;
		if (arst_n && averages.valid && averages.ready) begin
			got.average[0] = averages.average_ch0;
			got.average[1] = averages.average_ch1;
			got.average[2] = averages.average_ch2;
			got.average[3] = averages.average_ch3;
			got.count      = averages.window_count;
			got.frozen     = averages.window_frozen;
			if (expected_averages.size() == 0) begin
				$display("%0t: average word with none expected: %h", $time, got);
				fail_count++;
			end else begin
				want = expected_averages.pop_front();
				for (int c = 0; c < mwa_pkg::CHANNELS; c++)
					if (got.average[c] !== want.average[c]) begin
						$display("%0t: average_ch%0d expected %0d, got %0d", $time, c,
							$signed(want.average[c]), $signed(got.average[c]));
						fail_count++;
					end
				if (got.count !== want.count) begin
					$display("%0t: window_count expected %0d, got %0d", $time,
						want.count, got.count);
					fail_count++;
				end
				if (got.frozen !== want.frozen) begin
					$display("%0t: window_frozen expected %0b, got %0b", $time,
						want.frozen, got.frozen);
					fail_count++;
				end
			end
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("[moving_window_average_filter] ERROR");
		$finish;
	end

	initial begin
		samples.valid         = 1'b0;
		samples.command       = CMD_SAMPLE;
		samples.sample_ch0    = '0;
		samples.sample_ch1    = '0;
		samples.sample_ch2    = '0;
		samples.sample_ch3    = '0;
		averages.ready        = 1'b0;
		cfg.valid             = 1'b0;
		cfg.integration_ticks = mwa_pkg::TICKS_RESET;
		restart_window(mwa_pkg::TICKS_RESET);
		repeat (11) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// reset setting: a tick before any sample is dropped, extremes and truncation
		push_word(tick());
		push_word(vec(S_MAX, S_MAX, S_MAX, S_MAX));
		push_word(vec(S_MIN, S_MIN, S_MIN, S_MIN));
		push_word(vec(S_MIN, S_MAX, -1, 1));
		push_word(tick());
		push_word(tick());
		push_word(vec(-1, -1, -1, -1));
		push_word(vec(0, 1, -2, 3));

		// zero integration time: freeze on the first tick, later ticks dropped
		settle();
		write_ticks(16'd0);
		push_word(vec(5, -5, 7, -7));
		push_word(tick());
		push_word(vec(S_MAX, S_MIN, S_MAX, S_MIN));
		push_word(tick());
		push_word(vec(S_MIN, S_MIN, 0, 0));
		push_word(vec(3, -3, 2, -2));

		// shortest non-zero integration time
		settle();
		write_ticks(16'd1);
		push_word(tick());
		push_word(vec(-7, 7, -1, 1));
		push_word(vec(-8, 8, 0, 0));
		push_word(tick());
		push_word(vec(1, 2, 3, 4));
		push_word(vec(-9, 9, -9, 9));

		run_phase(16'd1, $urandom_range(35, 55), 20, LEAN_SMALL);
		run_phase(16'd0, $urandom_range(35, 55), 30, LEAN_EDGE);
		run_phase(16'($urandom_range(2, 20)), $urandom_range(35, 55), 50, LEAN_ANY);
		run_phase(16'hFFFF, $urandom_range(35, 55), 40, LEAN_LOW);
		run_phase(16'($urandom_range(21, 300)), $urandom_range(35, 55), 70, LEAN_SMALL);
		run_phase(16'd2, $urandom_range(35, 55), 25, LEAN_HIGH);
		// long growing window while the timer still runs
		run_phase(16'hFFFF, 350, 2, LEAN_HIGH);

		settle();
		tail_quiet <= 1'b1;
		run_phase(16'($urandom_range(2, 9)), 50, 30, LEAN_ANY);

		settle();
		if (fail_count == 0)
			$display("[moving_window_average_filter] OK");
		else
			$display("[moving_window_average_filter] ERROR");
		$finish;
	end

endmodule
